// ===== rtl/core/dhtc_pkg.sv =====
// Package for the detector hit timing classifier.
// Holds widths, sizes, register indexes and shared types; no dependencies.
`default_nettype none
package dhtc_pkg;
  localparam int NUM_MODULES = 16;
  localparam int MAX_HITS = 1024;
  localparam int PIXELS_PER_GROUP = 8;
  localparam int PIXEL_SPAN = 512;
  localparam int GROUPS = (PIXEL_SPAN + PIXELS_PER_GROUP - 1) / PIXELS_PER_GROUP;
  localparam int MOD_W = 4;
  localparam int GRP_W = $clog2(GROUPS);
  localparam int KEY_W = MOD_W + GRP_W;
  localparam int HIT_AW = $clog2(MAX_HITS);
  localparam int CNT_W = 11;
  localparam int EP_W = 8;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;
  localparam logic signed [17:0] NO_REF = -18'sd99999;

  typedef enum logic [2:0] {
    REG_HEIGHT_LOW = 3'd0, REG_HEIGHT_HIGH = 3'd1, REG_WIDTH_LOW = 3'd2,
    REG_WIDTH_HIGH = 3'd3, REG_PART_LOW = 3'd4, REG_PART_HIGH = 3'd5,
    REG_LASER_LOW = 3'd6, REG_LASER_HIGH = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_WIPE, ST_LOAD, ST_STORE, ST_REPLAY, ST_EMIT, ST_CLEAR
  } state_t;

  typedef struct packed {
    logic             keep;
    logic             last;
    logic             good;
    logic             cal;
    logic [MOD_W-1:0] mod;
    logic [GRP_W-1:0] grp;
    logic signed [15:0] t;
  } qitem_t;

  typedef struct packed {
    logic signed [17:0] part_low;
    logic signed [17:0] part_high;
    logic signed [17:0] laser_low;
    logic signed [17:0] laser_high;
  } win_t;
endpackage
`default_nettype wire

// ===== rtl/core/dhtc_front.sv =====
// Front end: accepts hits, checks module and pulse windows, pushes to queue.
// Depends on dhtc_pkg.
`default_nettype none
module dhtc_front import dhtc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_module_id,
  input  wire logic [9:0]  in_pixel_id,
  input  wire logic [2:0]  in_asic_channel,
  input  wire logic signed [15:0] in_raw_time,
  input  wire logic [11:0] in_pulse_height,
  input  wire logic [7:0]  in_pulse_width,
  input  wire logic        in_last_hit,
  input  wire logic [11:0] height_low,
  input  wire logic [11:0] height_high,
  input  wire logic [7:0]  width_low,
  input  wire logic [7:0]  width_high,
  output qitem_t           q_data,
  output logic             q_valid,
  input  wire logic        q_pop
);
  qitem_t q_mem [QDEPTH];
  logic [QAW:0] cnt_r, cnt_nxt;
  logic [QAW-1:0] wp_r, rp_r;
  logic push;
  logic [9:0] pm1;
  qitem_t it;

  assign in_ready = cnt_r != QDEPTH[QAW:0];
  assign push = in_valid && in_ready;
  assign q_valid = cnt_r != '0;
  assign q_data = q_mem[rp_r];

  always_comb begin
    pm1 = in_pixel_id - 10'd1;
    it.keep = in_module_id != 5'd0 && in_module_id <= 5'(NUM_MODULES);
    it.last = in_last_hit;
    it.good = !(in_pulse_height < height_low || in_pulse_height > height_high ||
                in_pulse_width < width_low || in_pulse_width > width_high);
    it.cal = in_asic_channel == 3'd0;
    it.mod = MOD_W'(in_module_id - 5'd1);
    it.grp = (in_pixel_id == 10'd0) ? '0 : GRP_W'(pm1 / 10'(PIXELS_PER_GROUP));
    it.t = in_raw_time;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wp_r] <= it;
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= '0; rp_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/dhtc_back.sv =====
// Back end: buffers hits, builds reference table, replays, emits counts.
// Depends on dhtc_pkg.
`default_nettype none
module dhtc_back import dhtc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  qitem_t           q_data,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  win_t             win,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_module_index,
  output logic [10:0]      out_all_count,
  output logic [10:0]      out_good_count,
  output logic [10:0]      out_bad_count,
  output logic [10:0]      out_particle_count,
  output logic [10:0]      out_laser_count,
  output logic [10:0]      out_cal_count,
  output logic [10:0]      out_other_count,
  output logic             out_last_module
);
  localparam int NREF = NUM_MODULES * GROUPS;
  localparam int HW = 1 + MOD_W + GRP_W + 16;
  localparam int RW = EP_W + 16;

  logic [HW-1:0] hbuf [MAX_HITS];
  logic [RW-1:0] rtab [NREF];
  logic [CNT_W-1:0] c_all_r [NUM_MODULES];
  logic [CNT_W-1:0] c_good_r [NUM_MODULES];
  logic [CNT_W-1:0] c_part_r [NUM_MODULES];
  logic [CNT_W-1:0] c_las_r [NUM_MODULES];
  logic [CNT_W-1:0] c_cal_r [NUM_MODULES];
  logic [CNT_W-1:0] c_oth_r [NUM_MODULES];

  state_t st_r, st_nxt;
  logic [HIT_AW:0] total_r;
  logic [HIT_AW:0] rd_r;
  logic [MOD_W-1:0] em_r;
  logic [EP_W-1:0] ep_r;
  logic [KEY_W-1:0] wipe_r;
  logic rv_r, rv2_r;
  logic [HW-1:0] hrd_r;
  logic [RW-1:0] rt_rd_r;
  logic cal2_r;
  logic [MOD_W-1:0] mod2_r;
  logic signed [15:0] t2_r;
  logic store, set_ref, wipe;
  logic [KEY_W-1:0] wkey, hkey, raddr;
  logic ref_ok;
  logic signed [18:0] d;
  logic in_p, in_l, issue;

  assign wkey = {q_data.mod, q_data.grp};
  assign hkey = hrd_r[KEY_W+15:16];
  assign raddr = (st_r == ST_LOAD) ? wkey : hkey;
  assign ref_ok = rt_rd_r[RW-1:16] == ep_r;

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    store = 1'b0;
    set_ref = 1'b0;
    wipe = 1'b0;
    issue = 1'b0;
    out_valid = 1'b0;
    case (st_r)
      ST_WIPE: begin
        wipe = 1'b1;
        if (wipe_r == KEY_W'(NREF - 1)) st_nxt = ST_LOAD;
      end
      ST_LOAD: if (q_valid) st_nxt = ST_STORE;
      ST_STORE: begin
        q_pop = 1'b1;
        store = q_data.keep && total_r != (HIT_AW+1)'(MAX_HITS);
        set_ref = store && q_data.cal && !ref_ok;
        st_nxt = q_data.last ? ST_REPLAY : ST_LOAD;
      end
      ST_REPLAY: begin
        issue = rd_r < total_r;
        if (!issue && !rv_r && !rv2_r) st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready && em_r == MOD_W'(NUM_MODULES - 1)) st_nxt = ST_CLEAR;
      end
      ST_CLEAR: st_nxt = (ep_r == '1) ? ST_WIPE : ST_LOAD;
      default: st_nxt = ST_WIPE;
    endcase
    d = 19'(t2_r) - (ref_ok ? 19'($signed(rt_rd_r[15:0])) : 19'(NO_REF));
    in_p = d > win.part_low && d < win.part_high;
    in_l = d > win.laser_low && d < win.laser_high;
  end

  assign out_module_index = em_r;
  assign out_all_count = c_all_r[em_r];
  assign out_good_count = c_good_r[em_r];
  assign out_bad_count = c_all_r[em_r] - c_good_r[em_r];
  assign out_particle_count = c_part_r[em_r];
  assign out_laser_count = c_las_r[em_r];
  assign out_cal_count = c_cal_r[em_r];
  assign out_other_count = c_oth_r[em_r];
  assign out_last_module = em_r == MOD_W'(NUM_MODULES - 1);

  always_ff @(posedge clk) begin
    if (store) hbuf[total_r[HIT_AW-1:0]] <= {q_data.cal, wkey, q_data.t};
    if (issue) hrd_r <= hbuf[rd_r[HIT_AW-1:0]];
    if (wipe) rtab[wipe_r] <= '0;
    else if (set_ref) rtab[wkey] <= {ep_r, q_data.t};
    rt_rd_r <= rtab[raddr];
    if (rv_r) begin
      cal2_r <= hrd_r[HW-1];
      mod2_r <= hkey[KEY_W-1:GRP_W];
      t2_r <= hrd_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_WIPE; total_r <= '0; rd_r <= '0; em_r <= '0;
      rv_r <= 1'b0; rv2_r <= 1'b0; wipe_r <= '0; ep_r <= EP_W'(1);
      for (int i = 0; i < NUM_MODULES; i++) begin
        c_all_r[i] <= '0; c_good_r[i] <= '0; c_part_r[i] <= '0;
        c_las_r[i] <= '0; c_cal_r[i] <= '0; c_oth_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      rv_r <= issue;
      rv2_r <= rv_r;
      if (wipe) wipe_r <= wipe_r + 1'b1;
      if (issue) rd_r <= rd_r + 1'b1;
      if (store) begin
        total_r <= total_r + 1'b1;
        c_all_r[q_data.mod] <= c_all_r[q_data.mod] + 1'b1;
        if (q_data.good) c_good_r[q_data.mod] <= c_good_r[q_data.mod] + 1'b1;
      end
      if (rv2_r) begin
        if (cal2_r) c_cal_r[mod2_r] <= c_cal_r[mod2_r] + 1'b1;
        else if (in_p) c_part_r[mod2_r] <= c_part_r[mod2_r] + 1'b1;
        else if (in_l) c_las_r[mod2_r] <= c_las_r[mod2_r] + 1'b1;
        else c_oth_r[mod2_r] <= c_oth_r[mod2_r] + 1'b1;
      end
      if (out_valid && out_ready) em_r <= em_r + 1'b1;
      if (st_r == ST_CLEAR) begin
        total_r <= '0; rd_r <= '0; em_r <= '0;
        ep_r <= (ep_r == '1) ? EP_W'(1) : ep_r + 1'b1;
        for (int i = 0; i < NUM_MODULES; i++) begin
          c_all_r[i] <= '0; c_good_r[i] <= '0; c_part_r[i] <= '0;
          c_las_r[i] <= '0; c_cal_r[i] <= '0; c_oth_r[i] <= '0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/detector_hit_timing_classifier.sv =====
// Top level of the detector hit timing classifier: config registers, front, back.
// Depends on dhtc_pkg, dhtc_front and dhtc_back.
// Hits enter through a four-entry queue; the back end handles each hit in a lookup
// state and a store state, looking up its group's reference entry and then storing
// it, so once the queue is full the input waits on both. After the last hit the
// back end replays the buffered hits, one per cycle, through its read registers,
// then emits 16 module records, one per accepted output cycle, and then clears its
// counts. Reference entries carry an 8-bit event mark; after reset and after every
// 255th event a clearing pass over the reference table runs, during which no hit
// leaves the queue.
`default_nettype none
module detector_hit_timing_classifier import dhtc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_module_id,
  input  wire logic [9:0]  in_pixel_id,
  input  wire logic [2:0]  in_asic_channel,
  input  wire logic signed [15:0] in_raw_time,
  input  wire logic [11:0] in_pulse_height,
  input  wire logic [7:0]  in_pulse_width,
  input  wire logic        in_last_hit,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [17:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_module_index,
  output logic [10:0]      out_all_count,
  output logic [10:0]      out_good_count,
  output logic [10:0]      out_bad_count,
  output logic [10:0]      out_particle_count,
  output logic [10:0]      out_laser_count,
  output logic [10:0]      out_cal_count,
  output logic [10:0]      out_other_count,
  output logic             out_last_module
);
  logic [11:0] hl_r, hh_r;
  logic [7:0] wl_r, wh_r;
  win_t win_r;
  qitem_t q_data;
  logic q_valid, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r <= 12'd100; hh_r <= 12'd2048; wl_r <= 8'd3; wh_r <= 8'd10;
      win_r.part_low <= -18'sd50; win_r.part_high <= 18'sd50;
      win_r.laser_low <= -18'sd200; win_r.laser_high <= -18'sd50;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_HEIGHT_LOW:  hl_r <= cfg_data[11:0];
        REG_HEIGHT_HIGH: hh_r <= cfg_data[11:0];
        REG_WIDTH_LOW:   wl_r <= cfg_data[7:0];
        REG_WIDTH_HIGH:  wh_r <= cfg_data[7:0];
        REG_PART_LOW:    win_r.part_low <= cfg_data;
        REG_PART_HIGH:   win_r.part_high <= cfg_data;
        REG_LASER_LOW:   win_r.laser_low <= cfg_data;
        REG_LASER_HIGH:  win_r.laser_high <= cfg_data;
        default: ;
      endcase
    end
  end

  dhtc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_module_id, .in_pixel_id,
    .in_asic_channel, .in_raw_time, .in_pulse_height, .in_pulse_width,
    .in_last_hit, .height_low(hl_r), .height_high(hh_r), .width_low(wl_r),
    .width_high(wh_r), .q_data, .q_valid, .q_pop
  );

  dhtc_back u_back (
    .clk, .rst_n, .q_data, .q_valid, .q_pop, .win(win_r), .out_valid, .out_ready,
    .out_module_index, .out_all_count, .out_good_count, .out_bad_count,
    .out_particle_count, .out_laser_count, .out_cal_count, .out_other_count,
    .out_last_module
  );

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_all_count == out_good_count + out_bad_count)
    else $error("good plus bad differs from all");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_module |=> !out_valid)
    else $error("records after last module");
endmodule
`default_nettype wire

// ===== sim/detector_hit_timing_classifier_test.sv =====
// Testbench for detector_hit_timing_classifier: drives events of hits, predicts the
// per-module count records and checks every record field by field.
// Depends on dhtc_pkg and the RTL of the classifier.
`default_nettype none
module detector_hit_timing_classifier_test;
  import dhtc_pkg::*;

  typedef struct {
    logic [4:0]  module_id;
    logic [9:0]  pixel_id;
    logic [2:0]  asic_channel;
    logic [15:0] raw_time;
    logic [11:0] pulse_height;
    logic [7:0]  pulse_width;
    logic        last_hit;
  } hit_in_t;

  typedef struct {
    int mod;
    int grp;
    bit cal;
    int t;
  } kept_hit_t;

  typedef enum int {K_ALL, K_GOOD, K_BAD, K_PART, K_LASER, K_CAL, K_OTHER, K_N} kind_e;

  typedef struct {
    logic [3:0]  idx;
    logic [10:0] cnt [K_N];
    logic        last_mod;
  } module_record_t;

  localparam int NGRP = 64;

  logic clk, rst_n;
  logic in_valid, in_ready, in_last_hit;
  logic [4:0] in_module_id;
  logic [9:0] in_pixel_id;
  logic [2:0] in_asic_channel;
  logic signed [15:0] in_raw_time;
  logic [11:0] in_pulse_height;
  logic [7:0] in_pulse_width;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [17:0] cfg_data;
  logic out_valid, out_ready, out_last_module;
  logic [3:0] out_module_index;
  logic [10:0] out_all_count, out_good_count, out_bad_count, out_particle_count;
  logic [10:0] out_laser_count, out_cal_count, out_other_count;

  detector_hit_timing_classifier uut (.*);

  hit_in_t pending_hits[$];
  module_record_t expected_records[$];
  kept_hit_t event_hits[$];
  bit ref_set [NUM_MODULES*NGRP];
  int ref_t [NUM_MODULES*NGRP];
  int tally [NUM_MODULES][K_N];
  logic [11:0] h_lo, h_hi;
  logic [7:0] w_lo, w_hi;
  logic signed [17:0] p_lo, p_hi, l_lo, l_hi;

  int send_idle_pct, recv_idle_pct;
  int hold_req, hold_seen, hold_left;
  bit in_acc, cfg_acc, failed;
  string kind_name [K_N] = '{"all", "good", "bad", "particle", "laser", "cal", "other"};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("detector_hit_timing_classifier verification failed");
    $finish;
  end

  function automatic void clear_event();
    event_hits.delete();
    foreach (ref_set[i]) ref_set[i] = 0;
    foreach (tally[m, k]) tally[m][k] = 0;
  endfunction

  function automatic void classify_hit(hit_in_t h);
    int m, g, key, d, ref_val;
    kind_e k;
    module_record_t r;
    if (h.module_id >= 1 && h.module_id <= NUM_MODULES && event_hits.size() < MAX_HITS) begin
      m = h.module_id - 1;
      g = (h.pixel_id == 0) ? 0 : (int'(h.pixel_id) - 1) / PIXELS_PER_GROUP;
      g = g % NGRP;
      key = m * NGRP + g;
      tally[m][K_ALL]++;
      if (h.pulse_height < h_lo || h.pulse_height > h_hi ||
          h.pulse_width < w_lo || h.pulse_width > w_hi)
        tally[m][K_BAD]++;
      else
        tally[m][K_GOOD]++;
      if (h.asic_channel == 0 && !ref_set[key]) begin
        ref_set[key] = 1;
        ref_t[key] = $signed(h.raw_time);
      end
      event_hits.insert(event_hits.size(),
                        kept_hit_t'{m, g, h.asic_channel == 0, $signed(h.raw_time)});
    end
    if (!h.last_hit) return;
    foreach (event_hits[i]) begin
      key = event_hits[i].mod * NGRP + event_hits[i].grp;
      ref_val = ref_set[key] ? ref_t[key] : -99999;
      d = event_hits[i].t - ref_val;
      if (event_hits[i].cal) k = K_CAL;
      else if (d > int'(p_lo) && d < int'(p_hi)) k = K_PART;
      else if (d > int'(l_lo) && d < int'(l_hi)) k = K_LASER;
      else k = K_OTHER;
      tally[event_hits[i].mod][k]++;
    end
    for (int mi = 0; mi < NUM_MODULES; mi++) begin
      r.idx = 4'(mi);
      for (int c = 0; c < K_N; c++) r.cnt[c] = 11'(tally[mi][c]);
      r.last_mod = (mi == NUM_MODULES - 1);
      expected_records.insert(expected_records.size(), r);
    end
    clear_event();
  endfunction

  // input side: sample at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    in_acc = in_valid && in_ready;
    cfg_acc = cfg_valid && cfg_ready;
    if (in_valid && in_ready)
      classify_hit('{in_module_id, in_pixel_id, in_asic_channel, in_raw_time,
                     in_pulse_height, in_pulse_width, in_last_hit});
  end

  always @(negedge clk) begin
    hit_in_t h;
    if (rst_n && (!in_valid || in_acc)) begin
      if (pending_hits.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        h = pending_hits.pop_front();
        in_valid <= 1;
        in_module_id <= h.module_id;
        in_pixel_id <= h.pixel_id;
        in_asic_channel <= h.asic_channel;
        in_raw_time <= h.raw_time;
        in_pulse_height <= h.pulse_height;
        in_pulse_width <= h.pulse_width;
        in_last_hit <= h.last_hit;
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    module_record_t e;
    logic [10:0] got [K_N];
    if (out_valid && out_ready) begin
      got = '{out_all_count, out_good_count, out_bad_count, out_particle_count,
              out_laser_count, out_cal_count, out_other_count};
      if (expected_records.size() == 0) begin
        $display("%0t: record with nothing expected, module %0d", $time, out_module_index);
        failed = 1;
      end else begin
        e = expected_records.pop_front();
        if (out_module_index !== e.idx) begin
          $display("%0t: module_index expected %0d actual %0d", $time, e.idx,
                   out_module_index);
          failed = 1;
        end
        for (int c = 0; c < K_N; c++)
          if (got[c] !== e.cnt[c]) begin
            $display("%0t: module %0d %s count expected %0d actual %0d", $time, e.idx,
                     kind_name[c], e.cnt[c], got[c]);
            failed = 1;
          end
        if (out_last_module !== e.last_mod) begin
          $display("%0t: last_module expected %0d actual %0d", $time, e.last_mod,
                   out_last_module);
          failed = 1;
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [17:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_acc);
    cfg_valid <= 0;
    case (idx)
      REG_HEIGHT_LOW:  h_lo = val[11:0];
      REG_HEIGHT_HIGH: h_hi = val[11:0];
      REG_WIDTH_LOW:   w_lo = val[7:0];
      REG_WIDTH_HIGH:  w_hi = val[7:0];
      REG_PART_LOW:    p_lo = val;
      REG_PART_HIGH:   p_hi = val;
      REG_LASER_LOW:   l_lo = val;
      REG_LASER_HIGH:  l_hi = val;
      default: ;
    endcase
  endtask

  task automatic write_all(int h0, int h1, int w0, int w1, int a, int b, int c, int d);
    write_reg(REG_HEIGHT_LOW, 18'(h0));
    write_reg(REG_HEIGHT_HIGH, 18'(h1));
    write_reg(REG_WIDTH_LOW, 18'(w0));
    write_reg(REG_WIDTH_HIGH, 18'(w1));
    write_reg(REG_PART_LOW, 18'(a));
    write_reg(REG_PART_HIGH, 18'(b));
    write_reg(REG_LASER_LOW, 18'(c));
    write_reg(REG_LASER_HIGH, 18'(d));
  endtask

  task automatic drain();
    while (pending_hits.size() > 0 || in_valid || expected_records.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_hit(int m, int px, int ch, int t, int ph, int pw, bit last);
    pending_hits.insert(pending_hits.size(),
                        hit_in_t'{5'(m), 10'(px), 3'(ch), 16'(t), 12'(ph), 8'(pw), last});
  endtask

  // mostly valid hits around a per-event base time with a few calibration hits
  task automatic add_random_event();
    int n, base, m, px;
    n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    base = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < n; i++) begin
      m = ($urandom_range(9) == 0) ? (($urandom_range(1)) ? 0 : $urandom_range(17, 31))
                                   : $urandom_range(1, NUM_MODULES);
      px = ($urandom_range(4) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 24);
      add_hit(m, px, ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 7),
              ($urandom_range(7) == 0) ? $urandom_range(0, 65535)
                                       : base + $urandom_range(0, 600) - 300,
              ($urandom_range(1)) ? $urandom_range(0, 4095) : $urandom_range(90, 110),
              ($urandom_range(1)) ? $urandom_range(0, 255) : $urandom_range(0, 12),
              i == n - 1);
    end
  endtask

  initial begin
    int phase_items;
    rst_n = 0;
    in_valid = 0; in_module_id = 0; in_pixel_id = 0; in_asic_channel = 0;
    in_raw_time = 0; in_pulse_height = 0; in_pulse_width = 0; in_last_hit = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0; out_ready = 0;
    failed = 0; hold_req = 0; hold_seen = 0; hold_left = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    h_lo = 100; h_hi = 2048; w_lo = 3; w_hi = 10;
    p_lo = -50; p_hi = 50; l_lo = -200; l_hi = -50;
    clear_event();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // window edges against one reference, missing reference, odd modules and pixels
    add_hit(1, 1, 0, 1000, 100, 3, 0);
    add_hit(1, 2, 0, 5, 2048, 10, 0);
    add_hit(1, 3, 1, 950, 99, 2, 0);
    add_hit(1, 4, 2, 951, 2049, 11, 0);
    add_hit(1, 5, 3, 1049, 0, 0, 0);
    add_hit(1, 6, 4, 1050, 4095, 255, 0);
    add_hit(1, 7, 5, 801, 500, 5, 0);
    add_hit(1, 8, 6, 800, 500, 5, 0);
    add_hit(2, 9, 7, -32768, 500, 5, 0);
    add_hit(2, 17, 7, 32767, 500, 5, 0);
    add_hit(16, 0, 0, -100, 500, 5, 0);
    add_hit(16, 512, 0, 200, 500, 5, 0);
    add_hit(16, 1023, 3, 210, 500, 5, 0);
    add_hit(16, 1, 3, -120, 500, 5, 0);
    add_hit(0, 3, 0, 0, 500, 5, 0);
    add_hit(17, 3, 0, 0, 500, 5, 0);
    add_hit(31, 1023, 7, -1, 4095, 255, 1);
    add_hit(31, 1, 1, 0, 0, 0, 1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_all(0, 4095, 0, 255, -131072, 131071, -131072, 131071);
        1: write_all(4095, 0, 255, 0, 131071, -131072, 131071, -131072);
        2: write_all($urandom_range(50, 150), $urandom_range(1000, 4095),
                     $urandom_range(0, 5), $urandom_range(5, 12),
                     -$urandom_range(0, 150), $urandom_range(0, 150),
                     -$urandom_range(150, 300), -$urandom_range(0, 150));
        default: write_all(100, 2048, 3, 10, -50, 50, -200, -50);
      endcase
      send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 7 : 0;
      phase_items = 0;
      while (phase_items < 80) begin
        add_random_event();
        if (phase == 2 && hold_req == 0) begin
          for (int j = 0; j < 4; j++) add_random_event();
          hold_req = 1;
        end
        phase_items = pending_hits.size() + phase_items;
        while (pending_hits.size() > 0) @(posedge clk);
      end
      drain();
    end

    if (!failed)
      $display("detector_hit_timing_classifier verification clean");
    else
      $display("detector_hit_timing_classifier verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/dhtc_pkg.sv
rtl/core/dhtc_front.sv
rtl/core/dhtc_back.sv
rtl/core/detector_hit_timing_classifier.sv
sim/detector_hit_timing_classifier_test.sv
